@@ rtl/hrpd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrpd_pkg
// Types, codes and lookup tables for the Hall rotor position decoder.
// ----------------------------------------------------------------------------
package hrpd_pkg;

    // Width of the timer counts kept inside the decoder
    localparam int COUNT_WIDTH = 16;

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [3:0]             hall_state_t;
    typedef logic [15:0]            angle_t;

    // Item function codes
    typedef enum logic [1:0] {
        FUNC_EDGE     = 2'd0,
        FUNC_OVERFLOW = 2'd1,
        FUNC_QUERY    = 2'd2,
        FUNC_NONE     = 2'd3
    } func_t;

    // Rotation sign, two's complement
    localparam logic signed [1:0] DIR_NONE = 2'sb00;
    localparam logic signed [1:0] DIR_FWD  = 2'sb01;
    localparam logic signed [1:0] DIR_REV  = 2'sb11;

    // No state decoded yet
    localparam hall_state_t STATE_NONE = 4'd8;

    // Degrees to 16-bit angle units, truncated
    localparam angle_t ANGLE_60  = angle_t'((60  * 65536) / 360);
    localparam angle_t ANGLE_120 = angle_t'((120 * 65536) / 360);
    localparam angle_t ANGLE_180 = angle_t'((180 * 65536) / 360);
    localparam angle_t ANGLE_240 = angle_t'((240 * 65536) / 360);
    localparam angle_t ANGLE_300 = angle_t'((300 * 65536) / 360);

    // Pad bits come in reversed order relative to the state
    function automatic logic [2:0] bit_reverse(input logic [2:0] bits);
        return {bits[0], bits[1], bits[2]};
    endfunction

    function automatic logic state_valid(input hall_state_t s);
        return (s >= 4'd1) && (s <= 4'd6);
    endfunction

    // Successor in the forward sequence 6, 2, 3, 1, 5, 4
    function automatic hall_state_t next_forward(input hall_state_t s);
        hall_state_t n;
        unique case (s)
            4'd1:    n = 4'd5;
            4'd2:    n = 4'd3;
            4'd3:    n = 4'd1;
            4'd4:    n = 4'd6;
            4'd5:    n = 4'd4;
            4'd6:    n = 4'd2;
            default: n = s;
        endcase
        return n;
    endfunction

    function automatic angle_t angle_of(input hall_state_t s);
        angle_t a;
        unique case (s)
            4'd1:    a = ANGLE_180;
            4'd2:    a = ANGLE_60;
            4'd3:    a = ANGLE_120;
            4'd4:    a = ANGLE_300;
            4'd5:    a = ANGLE_240;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

@@ rtl/hall_rotor_position_decoder_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hall_rotor_position_decoder_core
// Hall sensor state tracking, direction judgement, angle and period report.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one item per transfer: a Hall
//   edge with its capture count, a timer overflow, or a query with the live
//   count. Every item produces exactly one result on the output channel
//   (out_valid / out_stall): angle, angle_ok, direction, period, speed_ok and
//   the current hall_state.
//   An item passes through the input register, then the decode and state
//   update write the result register. Throughput is one item per cycle while
//   the receiver does not stall; the single decode stage between the two
//   registers sets that figure.
//   When the receiver stalls, the result register holds and the input
//   register takes one more item; in_stall rises once both are full.
//   Reset clears both registers to empty and sets the decoder to no known
//   state, zero latched count, overflow marked and unknown direction.
// ----------------------------------------------------------------------------
module hall_rotor_position_decoder_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         func,
    input  logic [2:0]         hall_bits,
    input  logic [15:0]        edge_count,
    input  logic [15:0]        live_count,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [15:0]        angle,
    output logic               angle_ok,
    output logic signed [1:0]  direction,
    output logic [15:0]        period,
    output logic               speed_ok,
    output logic [3:0]         hall_state
);

    // Input register
    logic                 in_valid_reg;
    hrpd_pkg::func_t      func_reg;
    logic [2:0]           hall_bits_reg;
    logic [15:0]          edge_count_reg;
    logic [15:0]          live_count_reg;

    // Decoder state
    hrpd_pkg::hall_state_t cur_reg, cur_next;
    hrpd_pkg::hall_state_t prev_reg, prev_next;
    hrpd_pkg::count_t      latched_reg, latched_next;
    logic                  ovf_reg, ovf_next;
    logic signed [1:0]     sign_reg, sign_next;

    // Result register
    logic                  out_valid_reg;
    hrpd_pkg::angle_t      angle_reg, angle_next;
    logic                  angle_ok_reg, angle_ok_next;
    logic signed [1:0]     dir_reg;
    logic [15:0]           period_reg, period_next;
    logic                  speed_ok_reg, speed_ok_next;
    hrpd_pkg::hall_state_t hall_state_reg;

    logic                  advance;
    hrpd_pkg::hall_state_t decoded;
    hrpd_pkg::count_t      edge_c;
    hrpd_pkg::count_t      live_c;
    hrpd_pkg::count_t      period_c;

    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            func_reg       <= hrpd_pkg::func_t'(func);
            hall_bits_reg  <= hall_bits;
            edge_count_reg <= edge_count;
            live_count_reg <= live_count;
        end
    end

    assign decoded = {1'b0, hrpd_pkg::bit_reverse(hall_bits_reg)};
    assign edge_c  = hrpd_pkg::COUNT_WIDTH'(edge_count_reg);
    assign live_c  = hrpd_pkg::COUNT_WIDTH'(live_count_reg);

    always_comb
    begin
        cur_next      = cur_reg;
        prev_next     = prev_reg;
        latched_next  = latched_reg;
        ovf_next      = ovf_reg;
        sign_next     = sign_reg;
        angle_next    = '0;
        angle_ok_next = 1'b0;
        period_c      = '0;
        speed_ok_next = 1'b0;

        case (func_reg)
            hrpd_pkg::FUNC_EDGE:
            begin
                if (decoded != cur_reg)
                begin
                    prev_next    = cur_reg;
                    cur_next     = decoded;
                    latched_next = edge_c;
                    ovf_next     = 1'b0;
                    if (hrpd_pkg::state_valid(decoded) && hrpd_pkg::state_valid(cur_reg))
                    begin
                        if (decoded == hrpd_pkg::next_forward(cur_reg))
                            sign_next = hrpd_pkg::DIR_FWD;
                        else if (cur_reg == hrpd_pkg::next_forward(decoded))
                            sign_next = hrpd_pkg::DIR_REV;
                        else
                            sign_next = hrpd_pkg::DIR_NONE;
                    end
                    else
                    begin
                        sign_next = hrpd_pkg::DIR_NONE;
                    end
                end
            end
            hrpd_pkg::FUNC_OVERFLOW:
            begin
                ovf_next = 1'b1;
            end
            hrpd_pkg::FUNC_QUERY:
            begin
                // Re-read the pads when no valid state is held
                if (!hrpd_pkg::state_valid(cur_reg))
                    cur_next = decoded;
                if (hrpd_pkg::state_valid(cur_next))
                begin
                    angle_next    = hrpd_pkg::angle_of(cur_next);
                    angle_ok_next = 1'b1;
                end
                if (ovf_reg)
                    period_c = '1;
                else
                    period_c = (live_c > latched_reg) ? live_c : latched_reg;
                speed_ok_next = (latched_reg != '0) && (sign_reg != hrpd_pkg::DIR_NONE);
            end
            default:
            begin
                cur_next = cur_reg;
            end
        endcase
    end

    assign period_next = 16'(period_c);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg       <= hrpd_pkg::STATE_NONE;
            prev_reg      <= hrpd_pkg::STATE_NONE;
            latched_reg   <= '0;
            ovf_reg       <= 1'b1;
            sign_reg      <= hrpd_pkg::DIR_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                cur_reg     <= cur_next;
                prev_reg    <= prev_next;
                latched_reg <= latched_next;
                ovf_reg     <= ovf_next;
                sign_reg    <= sign_next;
            end
            if (advance)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            angle_reg      <= angle_next;
            angle_ok_reg   <= angle_ok_next;
            dir_reg        <= sign_next;
            period_reg     <= period_next;
            speed_ok_reg   <= speed_ok_next;
            hall_state_reg <= cur_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign angle      = angle_reg;
    assign angle_ok   = angle_ok_reg;
    assign direction  = dir_reg;
    assign period     = period_reg;
    assign speed_ok   = speed_ok_reg;
    assign hall_state = hall_state_reg;

`ifndef SYNTHESIS
    // A known direction needs two valid states behind it
    assert property (@(posedge clk) disable iff (!rst_n)
        (sign_reg != hrpd_pkg::DIR_NONE) |->
            (hrpd_pkg::state_valid(cur_reg) && hrpd_pkg::state_valid(prev_reg)))
        else $error("direction known without two valid hall states");

    // Input side stalls only when both registers are full and the receiver stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled with room in the pipeline");

    // An invalid angle reports as zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !angle_ok) |-> (angle == 16'd0))
        else $error("nonzero angle flagged invalid");

    // Speed is only valid with a known direction
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && speed_ok) |-> (direction != hrpd_pkg::DIR_NONE))
        else $error("speed valid without direction");
`endif

endmodule
